/* sv/scan_cluster_cylinder_detect_defines.svh */
// Assertion macros shared by the cylinder detector RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SCAN_CLUSTER_CYLINDER_DETECT_DEFINES_SVH
`define SCAN_CLUSTER_CYLINDER_DETECT_DEFINES_SVH

`ifndef SYNTHESIS
`define SCCD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sccd assertion failed");
`define SCCD_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sccd forbidden condition seen");
`else
`define SCCD_ASSERT(label, clk, rst_n, prop)
`define SCCD_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* sv/sccd_pkg.sv */
// Types and constants of the scan cluster cylinder detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sccd_pkg;

	localparam int unsigned CoordW = 20;
	localparam int unsigned GapW = 19;
	localparam int unsigned CntRegW = 10;
	localparam int unsigned COUNT_WIDTH = 10;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned NumRegs = 4;
	localparam int unsigned PaddrW = $clog2(4 * NumRegs);
	localparam int unsigned PdataW = 32;

	localparam logic [GapW-1:0] GapXReset = GapW'(410);
	localparam logic [GapW-1:0] GapYReset = GapW'(410);
	localparam logic [CntRegW-1:0] MinPointsReset = CntRegW'(30);
	localparam logic [CntRegW-1:0] MaxPointsReset = CntRegW'(50);

	typedef enum logic [1:0] {
		REG_GAP_X      = 2'd0,
		REG_GAP_Y      = 2'd1,
		REG_MIN_POINTS = 2'd2,
		REG_MAX_POINTS = 2'd3
	} reg_idx_t;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   end_of_scan;
	} point_t;

	typedef struct packed {
		coord_t center_x;
		coord_t center_y;
		logic   last_of_run;
	} result_t;

	typedef struct packed {
		logic [GapW-1:0]    gap_x;
		logic [GapW-1:0]    gap_y;
		logic [CntRegW-1:0] min_points;
		logic [CntRegW-1:0] max_points;
	} cfg_t;

	// One queued job: the cluster closed by a point, then the final cluster.
	typedef struct packed {
		logic   a_en;
		coord_t a_first_x;
		coord_t a_first_y;
		coord_t a_last_x;
		coord_t a_last_y;
		logic   b_en;
		coord_t b_first_x;
		coord_t b_first_y;
		coord_t b_last_x;
		coord_t b_last_y;
	} job_t;

endpackage

`default_nettype wire

/* sv/sccd_front.sv */
// Front end: accepts points, tracks the open cluster and classifies each point.
// Depends on sccd_pkg; pushes result jobs into sccd_queue.
`timescale 1ns / 1ps
`default_nettype none

module sccd_front import sccd_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = sccd_pkg::COUNT_WIDTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   point_valid,
	output logic        point_stall,
	input  wire point_t point,
	input  wire logic   job_full,
	output logic        job_push,
	output job_t        job
);

	localparam int unsigned DiffW = CoordW + 1;
	localparam int unsigned MagW = (DiffW > GapW) ? DiffW : GapW;
	localparam int unsigned CmpW = (COUNT_WIDTH > CntRegW) ? COUNT_WIDTH : CntRegW;
	localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

	logic                   have_q;
	coord_t                 first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   accept;
	logic signed [DiffW-1:0] dx, dy;
	logic [DiffW-1:0]       adx, ady;
	logic                   near, join_pt, break_pt;
	logic [COUNT_WIDTH-1:0] count_join, count_b;
	logic                   size_ok_a, size_ok_b;

	assign point_stall = job_full;
	assign accept = point_valid && !point_stall;

	assign dx = DiffW'(point.point_x) - DiffW'(prev_x_q);
	assign dy = DiffW'(point.point_y) - DiffW'(prev_y_q);
	assign adx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
	assign ady = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
	assign near = (MagW'(adx) <= MagW'(cfg.gap_x)) && (MagW'(ady) <= MagW'(cfg.gap_y));
	assign join_pt = have_q && near;
	assign break_pt = have_q && !near;

	assign count_join = (count_q == CountMax) ? count_q : count_q + CountOne;
	assign count_b = join_pt ? count_join : CountOne;

	assign size_ok_a = (CmpW'(count_q) >= CmpW'(cfg.min_points))
		&& (CmpW'(count_q) <= CmpW'(cfg.max_points));
	assign size_ok_b = (CmpW'(count_b) >= CmpW'(cfg.min_points))
		&& (CmpW'(count_b) <= CmpW'(cfg.max_points));

	always_comb begin
		job.a_en = break_pt && (prev_x_q <= point.point_x) && size_ok_a;
		job.a_first_x = first_x_q;
		job.a_first_y = first_y_q;
		job.a_last_x = prev_x_q;
		job.a_last_y = prev_y_q;
		job.b_en = point.end_of_scan && size_ok_b;
		job.b_first_x = join_pt ? first_x_q : point.point_x;
		job.b_first_y = join_pt ? first_y_q : point.point_y;
		job.b_last_x = point.point_x;
		job.b_last_y = point.point_y;
	end

	assign job_push = accept && (job.a_en || job.b_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (point.end_of_scan) begin
				have_q <= 1'b0;
				first_x_q <= '0;
				first_y_q <= '0;
				prev_x_q <= '0;
				prev_y_q <= '0;
				count_q <= '0;
			end else if (join_pt) begin
				prev_x_q <= point.point_x;
				prev_y_q <= point.point_y;
				count_q <= count_join;
			end else begin
				have_q <= 1'b1;
				first_x_q <= point.point_x;
				first_y_q <= point.point_y;
				prev_x_q <= point.point_x;
				prev_y_q <= point.point_y;
				count_q <= CountOne;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/sccd_queue.sv */
// Short job queue between the front end and the back end.
// Depends on sccd_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none
`include "scan_cluster_cylinder_detect_defines.svh"

module sccd_queue import sccd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      head_valid,
	output logic      full
);

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] CntDepth = CntW'(QueueDepth);

	job_t            slot_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign head = slot_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full = (count_q == CntDepth);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`SCCD_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full && !pop)
	`SCCD_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && !head_valid)
	`SCCD_ASSERT(a_count_bound, clk, arst_n, count_q <= CntDepth)
	`SCCD_ASSERT(a_pop_drains, clk, arst_n, (pop && !push) |=> (count_q == $past(count_q) - CntW'(1)))

endmodule

`default_nettype wire

/* sv/sccd_back.sv */
// Back end: turns queued jobs into cylinder centres, one result a cycle unless result_stall holds it.
// Depends on sccd_pkg; reads jobs from sccd_queue and drives the result channel.
`timescale 1ns / 1ps
`default_nettype none
`include "scan_cluster_cylinder_detect_defines.svh"

module sccd_back import sccd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head,
	input  wire logic head_valid,
	output logic      pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result
);

	localparam int unsigned SumW = CoordW + 1;

	logic                  phase_q;
	logic                  result_valid_q;
	result_t               result_q;

	logic                  load, take, use_b;
	coord_t                sel_first_x, sel_first_y, sel_last_x, sel_last_y;
	logic signed [SumW-1:0] sum_x, sum_y;

	assign load = !result_valid_q || !result_stall;
	assign take = load && head_valid;
	assign use_b = phase_q || !head.a_en;
	assign pop = take && (use_b || !head.b_en);

	assign sel_first_x = use_b ? head.b_first_x : head.a_first_x;
	assign sel_first_y = use_b ? head.b_first_y : head.a_first_y;
	assign sel_last_x = use_b ? head.b_last_x : head.a_last_x;
	assign sel_last_y = use_b ? head.b_last_y : head.a_last_y;
	assign sum_x = SumW'(sel_first_x) + SumW'(sel_last_x);
	assign sum_y = SumW'(sel_first_y) + SumW'(sel_last_y);

	always_ff @(posedge clk) begin
		if (take) begin
			result_q.center_x <= sum_x[SumW-1:1];
			result_q.center_y <= sum_y[SumW-1:1];
			result_q.last_of_run <= use_b || !head.b_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				result_valid_q <= head_valid;
			end
			if (take) begin
				phase_q <= !use_b && head.b_en;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`SCCD_ASSERT(a_phase_has_job, clk, arst_n, phase_q |-> (head_valid && head.a_en && head.b_en))
	`SCCD_ASSERT(a_second_follows, clk, arst_n, (take && !use_b && head.b_en) |=> phase_q)
	`SCCD_ASSERT(a_pending_second, clk, arst_n, (result_valid_q && !result_q.last_of_run) |-> phase_q)

endmodule

`default_nettype wire

/* sv/scan_cluster_cylinder_detect.sv */
// Top level of the scan cluster cylinder detector: register port and datapath.
// Depends on sccd_pkg, sccd_front, sccd_queue and sccd_back.
//
//   Channel   Direction  Handshake                  Payload
//   point     in         point_valid / point_stall  point_t  (point_x, point_y, end_of_scan)
//   result    out        result_valid / result_stall result_t (center_x, center_y, last_of_run)
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One point is taken per cycle unless point_stall is high; each result is queued, then registered at the output.
// The back end delivers one result per cycle unless stalled, so a point closing two clusters holds it for both results.
// A four-job queue between front and back absorbs this; the point side stalls only when it fills.
// Reset clears the open cluster and loads the default thresholds and count range.
`timescale 1ns / 1ps
`default_nettype none

module scan_cluster_cylinder_detect import sccd_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = sccd_pkg::COUNT_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              point_valid,
	output logic                   point_stall,
	input  wire point_t            point,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output result_t                result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [PaddrW-1:0] paddr,
	input  wire logic [PdataW-1:0] pwdata,
	output logic [PdataW-1:0]      prdata,
	output logic                   pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_write;

	logic job_full, job_push, job_pop, head_valid;
	job_t job, head;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PaddrW-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_x <= GapXReset;
			cfg_q.gap_y <= GapYReset;
			cfg_q.min_points <= MinPointsReset;
			cfg_q.max_points <= MaxPointsReset;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_GAP_X: begin
					cfg_q.gap_x <= pwdata[GapW-1:0];
				end
				REG_GAP_Y: begin
					cfg_q.gap_y <= pwdata[GapW-1:0];
				end
				REG_MIN_POINTS: begin
					cfg_q.min_points <= pwdata[CntRegW-1:0];
				end
				REG_MAX_POINTS: begin
					cfg_q.max_points <= pwdata[CntRegW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAP_X: begin
				prdata = PdataW'(cfg_q.gap_x);
			end
			REG_GAP_Y: begin
				prdata = PdataW'(cfg_q.gap_y);
			end
			REG_MIN_POINTS: begin
				prdata = PdataW'(cfg_q.min_points);
			end
			REG_MAX_POINTS: begin
				prdata = PdataW'(cfg_q.max_points);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	sccd_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point      (point),
		.job_full   (job_full),
		.job_push   (job_push),
		.job        (job)
	);

	sccd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (job),
		.pop       (job_pop),
		.head      (head),
		.head_valid(head_valid),
		.full      (job_full)
	);

	sccd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (job_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

`default_nettype wire
